### hw/rtl/vtpd_pkg.sv
package vtpd_pkg;

   // Fixed point format and field widths.
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int REG_W     = 64;
   localparam int NUM_REGS  = 8;
   localparam int IDX_W     = 8;
   localparam int PROD_W    = 2 * DATA_W;
   // Four products of 64 bits summed without wrap.
   localparam int ACC_W     = PROD_W + 2;
   // Divider: numerator 2*(|x| << F) + |w|, denominator 2*|w|.
   localparam int QUO_W     = DATA_W;
   localparam int NUM_W     = ACC_W + FRAC_BITS + 2;
   localparam int DEN_W     = ACC_W + 1;
   localparam int REM_W     = DEN_W + QUO_W;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
   localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (FRAC_BITS + DATA_W));

   localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef word_type [3:0][3:0]      matrix_type;

   typedef struct packed {
      word_type [2:0] pos;
      word_type [2:0] nrm;
   } vertex_type;

   typedef struct packed {
      prod_type [3:0][3:0] pos_pp;
      prod_type [2:0][2:0] nrm_pp;
   } prod_set_type;

   typedef struct packed {
      acc_type [3:0] pos_acc;
      acc_type [2:0] nrm_acc;
   } sum_set_type;

   // One position coordinate on its way through the divider.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             big;
      logic             num_nz;
      logic             num_sgn;
   } lane_type;

   typedef struct packed {
      lane_type [2:0]   lane;
      logic [DEN_W-1:0] den;
      logic             w_zero;
      word_type [2:0]   nrm;
      logic             nrm_ovf;
   } div_work_type;

endpackage

### hw/rtl/vtpd_csr.sv
module vtpd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vtpd_pkg::IDX_W-1:0]    csr_index,
   input  logic [vtpd_pkg::REG_W-1:0]    csr_data,
   output vtpd_pkg::matrix_type          matrix
);

   logic [vtpd_pkg::REG_W-1:0] regs_ff [vtpd_pkg::NUM_REGS];

   assign csr_ready = 1'b1;

   // Matrix registers, reset to the identity; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[0] <= vtpd_pkg::ONE_LO;
         regs_ff[1] <= '0;
         regs_ff[2] <= vtpd_pkg::ONE_HI;
         regs_ff[3] <= '0;
         regs_ff[4] <= '0;
         regs_ff[5] <= vtpd_pkg::ONE_LO;
         regs_ff[6] <= '0;
         regs_ff[7] <= vtpd_pkg::ONE_HI;
      end else if (csr_valid && (csr_index < vtpd_pkg::IDX_W'(vtpd_pkg::NUM_REGS))) begin
         regs_ff[csr_index[$clog2(vtpd_pkg::NUM_REGS)-1:0]] <= csr_data;
      end
   end

   // Each register holds two coefficients of one row.
   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_col
         assign matrix[r][c] = regs_ff[r*2 + (c >> 1)][(c & 1)*vtpd_pkg::DATA_W +:
                                                       vtpd_pkg::DATA_W];
      end
   end

endmodule

### hw/rtl/vtpd_mac.sv
module vtpd_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  vtpd_pkg::vertex_type  vertex,
   input  vtpd_pkg::matrix_type  matrix,
   output logic                  out_valid,
   output vtpd_pkg::sum_set_type sums
);

   logic                   prod_valid_ff;
   vtpd_pkg::prod_set_type prod_ff;
   vtpd_pkg::prod_set_type prod_in;
   logic                   sum_valid_ff;
   vtpd_pkg::sum_set_type  sum_ff;
   vtpd_pkg::sum_set_type  sum_in;

   // Products: the w column of the position is a shift, the rest true multiplies.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in.pos_pp[r][c] = vtpd_pkg::PROD_W'(matrix[r][c] * vertex.pos[c]);
         end
         prod_in.pos_pp[r][3] = vtpd_pkg::prod_type'(matrix[r][3]) <<< vtpd_pkg::FRAC_BITS;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in.nrm_pp[r][c] = vtpd_pkg::PROD_W'(matrix[r][c] * vertex.nrm[c]);
         end
      end
   end

   // Row sums on the wide accumulator.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_in.pos_acc[r] = '0;
         for (int c = 0; c < 4; c++) begin
            sum_in.pos_acc[r] = sum_in.pos_acc[r] +
                                vtpd_pkg::ACC_W'($signed(prod_ff.pos_pp[r][c]));
         end
      end
      for (int r = 0; r < 3; r++) begin
         sum_in.nrm_acc[r] = '0;
         for (int c = 0; c < 3; c++) begin
            sum_in.nrm_acc[r] = sum_in.nrm_acc[r] +
                                vtpd_pkg::ACC_W'($signed(prod_ff.nrm_pp[r][c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
         sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign sums      = sum_ff;

   // A word taken while the pipeline moves is in the product stage next cycle.
   a_prod_fill: assert property (@(posedge clock) disable iff (reset)
      (in_valid && en) |=> prod_valid_ff)
      else $error("product stage lost a word");

   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> (sum_valid_ff == $past(sum_valid_ff)))
      else $error("sum stage moved during a stall");

   a_sum_fill: assert property (@(posedge clock) disable iff (reset)
      (prod_valid_ff && en) |=> sum_valid_ff)
      else $error("sum stage lost a word");

endmodule

### hw/rtl/vtpd_div_step.sv
module vtpd_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  vtpd_pkg::div_work_type in_work,
   output logic                   out_valid,
   output vtpd_pkg::div_work_type out_work
);

   logic                   valid_ff;
   vtpd_pkg::div_work_type work_ff;
   vtpd_pkg::div_work_type work_in;
   logic [vtpd_pkg::REM_W-1:0] den_top;
   logic [vtpd_pkg::REM_W-1:0] diff;

   // One restoring step per lane: compare against the denominator at the top
   // quotient weight, subtract when it fits, then shift the remainder up.
   always_comb begin
      work_in = in_work;
      den_top = vtpd_pkg::REM_W'({in_work.den, (vtpd_pkg::QUO_W-1)'(0)});
      diff    = '0;
      for (int i = 0; i < 3; i++) begin
         if (in_work.lane[i].rem >= den_top) begin
            diff                 = in_work.lane[i].rem - den_top;
            work_in.lane[i].quo  = {in_work.lane[i].quo[vtpd_pkg::QUO_W-2:0], 1'b1};
         end else begin
            diff                 = in_work.lane[i].rem;
            work_in.lane[i].quo  = {in_work.lane[i].quo[vtpd_pkg::QUO_W-2:0], 1'b0};
         end
         work_in.lane[i].rem = {diff[vtpd_pkg::REM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

### hw/rtl/vertex_transform_perspective_divide.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    pos_x..z, nrm_x..z, Q16.16
// rsp      out        rsp_valid/rsp_ready    out_pos_*, out_nrm_*, w_zero, overflow
// csr      in         csr_valid/csr_ready    csr_index, csr_data (64-bit matrix word)
//
// One word is accepted every cycle unless the output stalls; a result crosses two
// stages of multiply and sum, two of divider set-up, 32 divider steps (one quotient
// bit each) and the output register. The whole pipeline advances together whenever
// the output register is empty or being taken, so a stall holds every stage.
// Synchronous reset empties the pipeline and loads the identity matrix.
module vertex_transform_perspective_divide (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [vtpd_pkg::DATA_W-1:0] req_pos_x,
   input  logic signed [vtpd_pkg::DATA_W-1:0] req_pos_y,
   input  logic signed [vtpd_pkg::DATA_W-1:0] req_pos_z,
   input  logic signed [vtpd_pkg::DATA_W-1:0] req_nrm_x,
   input  logic signed [vtpd_pkg::DATA_W-1:0] req_nrm_y,
   input  logic signed [vtpd_pkg::DATA_W-1:0] req_nrm_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [vtpd_pkg::DATA_W-1:0] rsp_out_pos_x,
   output logic signed [vtpd_pkg::DATA_W-1:0] rsp_out_pos_y,
   output logic signed [vtpd_pkg::DATA_W-1:0] rsp_out_pos_z,
   output logic signed [vtpd_pkg::DATA_W-1:0] rsp_out_nrm_x,
   output logic signed [vtpd_pkg::DATA_W-1:0] rsp_out_nrm_y,
   output logic signed [vtpd_pkg::DATA_W-1:0] rsp_out_nrm_z,
   output logic                          rsp_w_zero,
   output logic                          rsp_overflow,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vtpd_pkg::IDX_W-1:0]    csr_index,
   input  logic [vtpd_pkg::REG_W-1:0]    csr_data
);

   localparam int F = vtpd_pkg::FRAC_BITS;

   logic                  en;
   vtpd_pkg::matrix_type  matrix;
   vtpd_pkg::vertex_type  vertex;
   logic                  sum_valid;
   vtpd_pkg::sum_set_type sums;

   // First set-up stage: magnitudes, signs and the finished normal.
   typedef struct packed {
      logic [2:0][vtpd_pkg::ACC_W-1:0] mag_n;
      logic [vtpd_pkg::ACC_W-1:0]      mag_d;
      logic [2:0]                      neg;
      logic [2:0]                      num_nz;
      logic [2:0]                      num_sgn;
      logic                            w_zero;
      vtpd_pkg::word_type [2:0]        nrm;
      logic                            nrm_ovf;
   } prep_type;

   logic     prep_valid_ff;
   prep_type prep_ff;
   prep_type prep_in;

   logic                   work_valid_ff;
   vtpd_pkg::div_work_type work_ff;
   vtpd_pkg::div_work_type work_in;

   logic                   step_valid [vtpd_pkg::DIV_STEPS+1];
   vtpd_pkg::div_work_type step_work  [vtpd_pkg::DIV_STEPS+1];

   logic                     out_valid_ff;
   vtpd_pkg::word_type [5:0] out_ff;
   vtpd_pkg::word_type [5:0] out_in;
   logic                     w_zero_ff;
   logic                     ovf_ff;
   logic                     ovf_in;

   typedef logic signed [vtpd_pkg::ACC_W-1:0] acc_local_type;

   acc_local_type            nrm_round [3];
   logic signed [vtpd_pkg::ACC_W-1:0] nrm_shift [3];

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   assign vertex.pos[0] = req_pos_x;
   assign vertex.pos[1] = req_pos_y;
   assign vertex.pos[2] = req_pos_z;
   assign vertex.nrm[0] = req_nrm_x;
   assign vertex.nrm[1] = req_nrm_y;
   assign vertex.nrm[2] = req_nrm_z;

   vtpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .matrix    (matrix)
   );

   vtpd_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .vertex    (vertex),
      .matrix    (matrix),
      .out_valid (sum_valid),
      .sums      (sums)
   );

   // Absolute values and signs for the divide; normal rounding and clipping.
   always_comb begin
      prep_in         = '0;
      prep_in.w_zero  = (sums.pos_acc[3] == '0);
      prep_in.mag_d   = sums.pos_acc[3][vtpd_pkg::ACC_W-1] ? -sums.pos_acc[3]
                                                           : sums.pos_acc[3];
      for (int i = 0; i < 3; i++) begin
         prep_in.num_sgn[i] = sums.pos_acc[i][vtpd_pkg::ACC_W-1];
         prep_in.num_nz[i]  = (sums.pos_acc[i] != '0);
         prep_in.neg[i]     = sums.pos_acc[i][vtpd_pkg::ACC_W-1] ^
                              sums.pos_acc[3][vtpd_pkg::ACC_W-1];
         prep_in.mag_n[i]   = sums.pos_acc[i][vtpd_pkg::ACC_W-1] ? -sums.pos_acc[i]
                                                               : sums.pos_acc[i];
         nrm_round[i] = sums.nrm_acc[i] + vtpd_pkg::ACC_W'(1 << (F - 1));
         nrm_shift[i] = nrm_round[i] >>> F;
         if ((nrm_shift[i][vtpd_pkg::ACC_W-1:vtpd_pkg::DATA_W-1] == '0) ||
             (nrm_shift[i][vtpd_pkg::ACC_W-1:vtpd_pkg::DATA_W-1] == '1)) begin
            prep_in.nrm[i] = nrm_shift[i][vtpd_pkg::DATA_W-1:0];
         end else begin
            prep_in.nrm[i]  = nrm_shift[i][vtpd_pkg::ACC_W-1] ? vtpd_pkg::WORD_MIN
                                                              : vtpd_pkg::WORD_MAX;
            prep_in.nrm_ovf = 1'b1;
         end
      end
   end

   // Second set-up stage: numerator, denominator and the quotient range check.
   always_comb begin
      work_in         = '0;
      work_in.den     = {prep_ff.mag_d, 1'b0};
      work_in.w_zero  = prep_ff.w_zero;
      work_in.nrm     = prep_ff.nrm;
      work_in.nrm_ovf = prep_ff.nrm_ovf;
      for (int i = 0; i < 3; i++) begin
         work_in.lane[i].rem     = vtpd_pkg::REM_W'(
            vtpd_pkg::NUM_W'({prep_ff.mag_n[i], F'(0), 1'b0}) +
            vtpd_pkg::NUM_W'(prep_ff.mag_d));
         work_in.lane[i].big     = work_in.lane[i].rem >=
                                   {prep_ff.mag_d, 1'b0, vtpd_pkg::QUO_W'(0)};
         work_in.lane[i].neg     = prep_ff.neg[i];
         work_in.lane[i].num_nz  = prep_ff.num_nz[i];
         work_in.lane[i].num_sgn = prep_ff.num_sgn[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
         work_valid_ff <= 1'b0;
      end else if (en) begin
         prep_valid_ff <= sum_valid;
         work_valid_ff <= prep_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
         work_ff <= work_in;
      end
   end

   // Divider chain, one quotient bit per stage.
   assign step_valid[0] = work_valid_ff;
   assign step_work[0]  = work_ff;

   for (genvar s = 0; s < vtpd_pkg::DIV_STEPS; s++) begin : g_step
      vtpd_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (step_valid[s]),
         .in_work   (step_work[s]),
         .out_valid (step_valid[s+1]),
         .out_work  (step_work[s+1])
      );
   end

   // Apply the sign, clip, and handle a zero w.
   always_comb begin
      vtpd_pkg::div_work_type fin;
      fin    = step_work[vtpd_pkg::DIV_STEPS];
      ovf_in = fin.nrm_ovf;
      for (int i = 0; i < 3; i++) begin
         out_in[3+i] = fin.nrm[i];
         if (fin.w_zero) begin
            if (!fin.lane[i].num_nz) begin
               out_in[i] = '0;
            end else begin
               out_in[i] = fin.lane[i].num_sgn ? vtpd_pkg::WORD_MIN : vtpd_pkg::WORD_MAX;
               ovf_in    = 1'b1;
            end
         end else if (!fin.lane[i].neg || (fin.lane[i].quo == '0 && !fin.lane[i].big)) begin
            if (fin.lane[i].big || fin.lane[i].quo[vtpd_pkg::QUO_W-1]) begin
               out_in[i] = vtpd_pkg::WORD_MAX;
               ovf_in    = 1'b1;
            end else begin
               out_in[i] = fin.lane[i].quo;
            end
         end else begin
            if (fin.lane[i].big ||
                (fin.lane[i].quo > vtpd_pkg::QUO_W'(vtpd_pkg::WORD_MIN))) begin
               out_in[i] = vtpd_pkg::WORD_MIN;
               ovf_in    = 1'b1;
            end else begin
               out_in[i] = -fin.lane[i].quo;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= step_valid[vtpd_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff    <= out_in;
         w_zero_ff <= step_work[vtpd_pkg::DIV_STEPS].w_zero;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_pos_x = out_ff[0];
   assign rsp_out_pos_y = out_ff[1];
   assign rsp_out_pos_z = out_ff[2];
   assign rsp_out_nrm_x = out_ff[3];
   assign rsp_out_nrm_y = out_ff[4];
   assign rsp_out_nrm_z = out_ff[5];
   assign rsp_w_zero    = w_zero_ff;
   assign rsp_overflow  = ovf_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_wzero_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_w_zero && (rsp_out_pos_x != '0)) |-> rsp_overflow)
      else $error("zero w clipped a position without overflow");

   a_prep_fill: assert property (@(posedge clock) disable iff (reset)
      (sum_valid && en) |=> prep_valid_ff)
      else $error("set-up stage lost a word");

endmodule

### test/vertex_transform_perspective_divide_tb.sv
`timescale 1ns / 100ps

module vertex_transform_perspective_divide_tb;
   import vtpd_pkg::*;

   // Register indexes of the matrix words, two coefficients per word.
   localparam logic [IDX_W-1:0] ROW0_COLS01 = 8'd0;
   localparam logic [IDX_W-1:0] ROW0_COLS23 = 8'd1;
   localparam logic [IDX_W-1:0] ROW1_COLS01 = 8'd2;
   localparam logic [IDX_W-1:0] ROW1_COLS23 = 8'd3;
   localparam logic [IDX_W-1:0] ROW2_COLS01 = 8'd4;
   localparam logic [IDX_W-1:0] ROW2_COLS23 = 8'd5;
   localparam logic [IDX_W-1:0] ROW3_COLS01 = 8'd6;
   localparam logic [IDX_W-1:0] ROW3_COLS23 = 8'd7;
   localparam logic [IDX_W-1:0] IDX_PAST_END = 8'd8;
   localparam logic [IDX_W-1:0] IDX_TOP      = 8'd255;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 60;

   typedef logic signed [127:0] wide_type;
   localparam wide_type W_MAX = 128'sh7FFFFFFF;
   localparam wide_type W_MIN = -128'sh80000000;

   typedef struct packed {
      word_type [2:0] pos;
      word_type [2:0] nrm;
      logic           w_zero;
      logic           overflow;
   } vertex_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   word_type req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   word_type req_nrm_x = '0, req_nrm_y = '0, req_nrm_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   word_type rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z;
   word_type rsp_out_nrm_x, rsp_out_nrm_y, rsp_out_nrm_z;
   logic rsp_w_zero, rsp_overflow;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_data = '0;

   // Our own copy of the matrix and the results still owed by the block.
   word_type          coeff [4][4];
   vertex_result_type pending_results [$];
   int                errors = 0;
   int                words_sent = 0;
   int                words_checked = 0;
   int                w_zero_seen = 0;
   int                overflow_seen = 0;
   int                cycles = 0;
   int                burst_left = 0;
   bit                gaps_on = 1'b1;
   int                stall_mode = 0;

   vertex_transform_perspective_divide dut (.*);

   always #5 clock = ~clock;

   // Multiply by the matrix, divide the position by w and round as the block does.
   function automatic vertex_result_type transform_vertex(input word_type [2:0] pos,
                                                          input word_type [2:0] nrm);
      vertex_result_type res;
      wide_type          pv [4];
      wide_type          sum [4];
      wide_type          mn, md, q, acc;
      logic              flip;
      res = '0;
      for (int i = 0; i < 3; i++) pv[i] = pos[i];
      pv[3] = wide_type'(1) <<< FRAC_BITS;
      for (int r = 0; r < 4; r++) begin
         sum[r] = '0;
         for (int c = 0; c < 4; c++) sum[r] += wide_type'(coeff[r][c]) * pv[c];
      end
      res.w_zero = (sum[3] == 0);
      for (int i = 0; i < 3; i++) begin
         if (res.w_zero) begin
            if (sum[i] == 0) begin
               res.pos[i] = '0;
            end else if (sum[i] < 0) begin
               res.pos[i] = WORD_MIN;
               res.overflow = 1'b1;
            end else begin
               res.pos[i] = WORD_MAX;
               res.overflow = 1'b1;
            end
         end else begin
            // Round to nearest, ties away from zero, on magnitudes.
            flip = (sum[i] < 0) != (sum[3] < 0);
            mn = (sum[i] < 0 ? -sum[i] : sum[i]) <<< FRAC_BITS;
            md = sum[3] < 0 ? -sum[3] : sum[3];
            q = (2 * mn + md) / (2 * md);
            if (!flip || q == 0) begin
               if (q > W_MAX) begin
                  res.pos[i] = WORD_MAX;
                  res.overflow = 1'b1;
               end else begin
                  res.pos[i] = q[31:0];
               end
            end else if (q > -W_MIN) begin
               res.pos[i] = WORD_MIN;
               res.overflow = 1'b1;
            end else begin
               res.pos[i] = -q[31:0];
            end
         end
      end
      // The normal has w = 0; round half up, then clip.
      for (int i = 0; i < 3; i++) begin
         acc = wide_type'(1) <<< (FRAC_BITS - 1);
         for (int c = 0; c < 3; c++) acc += wide_type'(coeff[i][c]) * wide_type'(nrm[c]);
         acc = acc >>> FRAC_BITS;
         if (acc > W_MAX) begin
            res.nrm[i] = WORD_MAX;
            res.overflow = 1'b1;
         end else if (acc < W_MIN) begin
            res.nrm[i] = WORD_MIN;
            res.overflow = 1'b1;
         end else begin
            res.nrm[i] = acc[31:0];
         end
      end
      return res;
   endfunction

   // Mostly small values, with zeros, extremes and full-width noise mixed in.
   function automatic word_type pick_value();
      int sel;
      sel = $urandom_range(0, 15);
      if (sel < 2) return '0;
      if (sel == 2) return WORD_MAX;
      if (sel == 3) return WORD_MIN;
      if (sel < 8) return word_type'($urandom);
      return word_type'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
   endfunction

   // Send one vertex; the sender works in bursts with random gaps.
   task automatic send_vertex(input word_type [2:0] pos, input word_type [2:0] nrm);
      int gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_pos_x <= pos[0];
      req_pos_y <= pos[1];
      req_pos_z <= pos[2];
      req_nrm_x <= nrm[0];
      req_nrm_y <= nrm[1];
      req_nrm_z <= nrm[2];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(transform_vertex(pos, nrm));
      words_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_random_vertex();
      word_type [2:0] pos, nrm;
      for (int i = 0; i < 3; i++) begin
         pos[i] = pick_value();
         nrm[i] = pick_value();
      end
      send_vertex(pos, nrm);
   endtask

   // Stop sending and wait until the block has handed back everything.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write a set of matrix words while the block is idle.
   task automatic load_words(input logic [IDX_W-1:0] idx [], input logic [REG_W-1:0] val []);
      drain();
      for (int k = 0; k < idx.size(); k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (idx[k] <= ROW3_COLS23) begin
            coeff[idx[k] / 2][(idx[k] % 2) * 2]     = val[k][31:0];
            coeff[idx[k] / 2][(idx[k] % 2) * 2 + 1] = val[k][63:32];
         end
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_matrix(input logic [REG_W-1:0] val [8]);
      logic [IDX_W-1:0] idx [] = '{ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
                                   ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23};
      logic [REG_W-1:0] v [] = new[8];
      foreach (val[k]) v[k] = val[k];
      load_words(idx, v);
   endtask

   function automatic logic [REG_W-1:0] pick_word();
      return {pick_value(), pick_value()};
   endfunction

   // Reset identity, extremes of every field, zero w, and the rounding ties.
   task automatic test_directed();
      logic [REG_W-1:0] m [8];
      word_type ext [5] = '{32'sd0, WORD_MAX, WORD_MIN, 32'sd1, -32'sd1};
      gaps_on = 1'b0;
      foreach (ext[k]) send_vertex({ext[k], ext[(k + 1) % 5], ext[(k + 2) % 5]},
                                   {ext[(k + 3) % 5], ext[(k + 4) % 5], ext[k]});
      // A zero bottom row makes w zero; numerators of each sign and zero.
      m = '{ONE_LO, 64'd0, ONE_HI, 64'd0, 64'd0, ONE_LO, 64'd0, 64'd0};
      load_matrix(m);
      send_vertex({32'sd5, -32'sd7, 32'sd0}, {32'sd1, 32'sd2, 32'sd3});
      send_vertex({WORD_MIN, WORD_MAX, -32'sd1}, {WORD_MAX, WORD_MIN, 32'sd0});
      // w of two and a half coefficient bring out both kinds of tie.
      m = '{64'h8000, 64'd0, ONE_HI, 64'd0, 64'd0, ONE_LO, 64'd0, ONE_HI << 1};
      load_matrix(m);
      send_vertex({32'sd1, -32'sd1, 32'sd3}, {32'sd1, 32'sd0, 32'sd0});
      send_vertex({-32'sd1, 32'sd1, -32'sd3}, {-32'sd1, -32'sd1, 32'sd1});
      send_vertex({32'sd2, 32'sd0, -32'sd2}, {32'sd3, -32'sd3, 32'sd0});
      // Negative w and the largest coefficients.
      m = '{64'h7FFFFFFF_7FFFFFFF, 64'h80000000_80000000, 64'h80000000_7FFFFFFF,
            64'h7FFFFFFF_80000000, 64'hFFFFFFFF_00000001, 64'h00000001_FFFFFFFF,
            64'd0, 64'hFFFF0000_00000000};
      load_matrix(m);
      foreach (ext[k]) send_vertex({ext[k], ext[4 - k], ext[(k + 2) % 5]},
                                   {ext[4 - k], ext[k], ext[(k + 1) % 5]});
      gaps_on = 1'b1;
   endtask

   // Random vertices against a run of matrices, extremes among them.
   task automatic test_random_matrices();
      logic [REG_W-1:0] m [8];
      logic [IDX_W-1:0] bad_idx [] = '{IDX_PAST_END, IDX_TOP};
      logic [REG_W-1:0] bad_val [] = '{~64'd0, 64'h80000000_80000000};
      for (int phase = 0; phase < 8; phase++) begin
         stall_mode = phase % 3;
         gaps_on = (phase != 2);
         foreach (m[k]) m[k] = pick_word();
         if (phase == 1) m = '{default: 64'd0};
         if (phase == 3) m = '{default: 64'h7FFFFFFF_7FFFFFFF};
         if (phase == 4) m = '{default: 64'h80000000_80000000};
         // Bottom row with only a z term, so w is often exactly zero.
         if (phase == 5) begin
            m[6] = 64'd0;
            m[7] = {32'd0, 32'($urandom_range(1, 3) << 16)};
         end
         load_matrix(m);
         if (phase == 6) load_words(bad_idx, bad_val);
         for (int n = 0; n < 200; n++) begin
            if (phase == 5 && n % 3 == 0) begin
               send_vertex({pick_value(), pick_value(), 32'sd0},
                           {pick_value(), pick_value(), pick_value()});
            end else begin
               send_random_vertex();
            end
         end
      end
   endtask

   // Let the pipeline run dry in mid-stream, then carry on.
   task automatic test_pause_and_refill();
      stall_mode = 1;
      for (int n = 0; n < 40; n++) send_random_vertex();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      for (int n = 0; n < 40; n++) send_random_vertex();
   endtask

   // The receiver stalls randomly, in long stretches, or not at all.
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ((cycles % 64) < 40) ? 1'b1 : ($urandom_range(0, 7) == 0);
      endcase
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      vertex_result_type exp_res, got;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_nrm_z, rsp_out_nrm_y, rsp_out_nrm_x,
                rsp_out_pos_z, rsp_out_pos_y, rsp_out_pos_x, rsp_w_zero, rsp_overflow};
         got.pos = {rsp_out_pos_z, rsp_out_pos_y, rsp_out_pos_x};
         got.nrm = {rsp_out_nrm_z, rsp_out_nrm_y, rsp_out_nrm_x};
         got.w_zero = rsp_w_zero;
         got.overflow = rsp_overflow;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected", $time);
         end else begin
            exp_res = pending_results.pop_front();
            words_checked++;
            w_zero_seen += got.w_zero;
            overflow_seen += got.overflow;
            for (int i = 0; i < 3; i++) begin
               if (got.pos[i] !== exp_res.pos[i]) begin
                  errors++;
                  if (errors < 40) $display("%0t: out_pos[%0d] expected %h got %h",
                                            $time, i, exp_res.pos[i], got.pos[i]);
               end
               if (got.nrm[i] !== exp_res.nrm[i]) begin
                  errors++;
                  if (errors < 40) $display("%0t: out_nrm[%0d] expected %h got %h",
                                            $time, i, exp_res.nrm[i], got.nrm[i]);
               end
            end
            if (got.w_zero !== exp_res.w_zero || got.overflow !== exp_res.overflow) begin
               errors++;
               if (errors < 40) $display("%0t: w_zero/overflow expected %b%b got %b%b",
                                         $time, exp_res.w_zero, exp_res.overflow,
                                         got.w_zero, got.overflow);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("vertex_transform_perspective_divide: mismatch");
         $finish;
      end
   end

   initial begin
      // Reset loads the identity matrix.
      foreach (coeff[r, c]) coeff[r][c] = (r == c) ? word_type'(1 << FRAC_BITS) : '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_matrices();
      test_pause_and_refill();
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0) errors++;
      $display("Checked %0d of %0d vertices over twelve matrix settings.",
               words_checked, words_sent);
      $display("Zero w seen %0d times, saturation %0d times.", w_zero_seen, overflow_seen);
      if (errors == 0) begin
         $display("vertex_transform_perspective_divide: match");
      end else begin
         $display("vertex_transform_perspective_divide: mismatch");
      end
      $finish;
   end

endmodule

### vertex_transform_perspective_divide.f
hw/rtl/vtpd_pkg.sv
hw/rtl/vtpd_csr.sv
hw/rtl/vtpd_mac.sv
hw/rtl/vtpd_div_step.sv
hw/rtl/vertex_transform_perspective_divide.sv
test/vertex_transform_perspective_divide_tb.sv
